// ===== rtl/core/swd_host_transfer_engine_macros.svh =====
// ----------------------------------------------------------------------------
// SWD host transfer engine: assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef SWD_HOST_TRANSFER_ENGINE_MACROS_SVH
`define SWD_HOST_TRANSFER_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SWD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// SWD host transfer engine: package
// Phase encoding, acknowledge and status codes, register map and header bits.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned CNT_W      = 6;

	// Transfer phases
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_HDR    = 4'd1,
		PH_TRN_A  = 4'd2,
		PH_ACK    = 4'd3,
		PH_TRN_R  = 4'd4,
		PH_RDATA  = 4'd5,
		PH_RPAR   = 4'd6,
		PH_TRN_RD = 4'd7,
		PH_TRN_WR = 4'd8,
		PH_WDATA  = 4'd9,
		PH_WPAR   = 4'd10
	} phase_t;

	// Item commands
	localparam logic CMD_REQ  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Acknowledge codes
	localparam logic [2:0] ACK_OK   = 3'd1;
	localparam logic [2:0] ACK_WAIT = 3'd2;

	// Completion status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_WAIT     = 2'd1;
	localparam logic [1:0] ST_FAULT    = 2'd2;
	localparam logic [1:0] ST_PARITY   = 2'd3;

	// Register select (byte address bit 2)
	localparam logic REG_RETRY = 1'b0;
	localparam logic REG_TRN   = 1'b1;

	localparam int unsigned HDR_BITS = 8;
	localparam int unsigned ACK_BITS = 3;

	// Header bit by position: start, APnDP, RnW, A2, A3, parity, stop, park
	function automatic logic header_bit(input logic [3:0] req, input logic [2:0] pos);
		logic b;
		case (pos)
			3'd0:    b = 1'b1;
			3'd1:    b = req[0];
			3'd2:    b = req[1];
			3'd3:    b = req[2];
			3'd4:    b = req[3];
			3'd5:    b = ^req;
			3'd6:    b = 1'b0;
			default: b = 1'b1;
		endcase
		return b;
	endfunction

	// Host owns the line in these phases
	function automatic logic host_drives(input phase_t ph);
		return (ph == PH_IDLE) || (ph == PH_HDR) || (ph == PH_WDATA) || (ph == PH_WPAR);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/swd_host_transfer_engine.sv =====
// Result: the result word of an accepted input word is registered and valid in the next cycle.
// Throughput: one word per cycle; the single output register is the only
//   buffering, so input stalls only while that register is full and stalled.
// Reset: arst_n clears phase, counters and output valid; retry_limit returns
//   to 3 and turnaround_cycles to 1.
// ----------------------------------------------------------------------------
// SWD host transfer engine
// One SWCLK period per tick word: header, turnaround, acknowledge with retry,
// read or write data phase with parity, and a done word with status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "swd_host_transfer_engine_macros.svh"

module swd_host_transfer_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           cmd,
	input  wire logic [3:0]                     request_bits,
	input  wire logic [swd_pkg::DATA_WIDTH-1:0] write_word,
	input  wire logic                           line_in,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                line_out,
	output logic                                line_drive,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [1:0]                          status,
	output logic [2:0]                          last_ack,
	output logic [swd_pkg::DATA_WIDTH-1:0]      read_word,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import swd_pkg::*;

	// configuration registers
	logic [3:0] retry_q;
	logic [2:0] trn_q;

	// transfer state
	phase_t                  phase_q, phase_d;
	logic [CNT_W-1:0]        bit_count_q, bit_count_d;
	logic [DATA_WIDTH-1:0]   shift_word_q, shift_word_d;
	logic                    parity_q, parity_d;
	logic [3:0]              tries_q, tries_d;
	logic [3:0]              held_req_q, held_req_d;
	logic [2:0]              ack_q, ack_d;

	// output register
	logic                    out_valid_q;
	logic                    line_out_q, line_drive_q, busy_q, done_q;
	logic [1:0]              status_q;
	logic [2:0]              last_ack_q;
	logic [DATA_WIDTH-1:0]   read_word_q;

	// per-item combinational results
	logic                    lo_c, drv_c, done_c;
	logic [1:0]              stat_c;
	logic [DATA_WIDTH-1:0]   rword_c;

	logic                    in_acc;
	logic                    cfg_wr;
	logic [CNT_W-1:0]        cnt_inc;
	logic [2:0]              trn_len;
	logic                    trn_end;
	logic [4:0]              bit_pos;

	// handshake
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;

	// configuration write and read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= 4'd3;
			trn_q   <= 3'd1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_RETRY) begin
				retry_q <= pwdata[3:0];
			end else begin
				trn_q <= pwdata[2:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_TRN) ? {29'd0, trn_q} : {28'd0, retry_q};

	// shared counters and compares
	assign cnt_inc = bit_count_q + CNT_W'(1);
	assign trn_len = (trn_q == 3'd0) ? 3'd1 : trn_q;
	assign trn_end = cnt_inc >= {{(CNT_W-3){1'b0}}, trn_len};
	assign bit_pos = bit_count_q[4:0];

	// next state
	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_word_d = shift_word_q;
		parity_d     = parity_q;
		tries_d      = tries_q;
		held_req_d   = held_req_q;
		ack_d        = ack_q;
		if (cmd == CMD_REQ) begin
			if (phase_q == PH_IDLE) begin
				held_req_d   = request_bits;
				shift_word_d = write_word;
				tries_d      = (retry_q == 4'd0) ? 4'd1 : retry_q;
				parity_d     = 1'b0;
				bit_count_d  = '0;
				phase_d      = PH_HDR;
			end
		end else begin
			case (phase_q)
				PH_HDR: begin
					bit_count_d = cnt_inc;
					if (bit_count_q >= CNT_W'(HDR_BITS - 1)) begin
						phase_d     = PH_TRN_A;
						bit_count_d = '0;
					end
				end
				PH_TRN_A: begin
					bit_count_d = cnt_inc;
					if (trn_end) begin
						phase_d     = PH_ACK;
						bit_count_d = '0;
						ack_d       = 3'd0;
					end
				end
				PH_ACK: begin
					if (bit_count_q < CNT_W'(ACK_BITS)) begin
						ack_d = ack_q | (3'(line_in) << bit_count_q[1:0]);
					end
					bit_count_d = cnt_inc;
					if (cnt_inc >= CNT_W'(ACK_BITS)) begin
						bit_count_d = '0;
						if (ack_d == ACK_OK) begin
							parity_d = 1'b0;
							phase_d  = held_req_q[1] ? PH_RDATA : PH_TRN_WR;
						end else begin
							tries_d = (tries_q != 4'd0) ? tries_q - 4'd1 : 4'd0;
							phase_d = PH_TRN_R;
						end
					end
				end
				PH_TRN_R: begin
					bit_count_d = cnt_inc;
					if (trn_end) begin
						bit_count_d = '0;
						phase_d     = (tries_q != 4'd0) ? PH_HDR : PH_IDLE;
					end
				end
				PH_RDATA: begin
					shift_word_d[bit_pos] = line_in;
					parity_d              = parity_q ^ line_in;
					bit_count_d           = cnt_inc;
					if (cnt_inc >= CNT_W'(DATA_WIDTH)) begin
						bit_count_d = '0;
						phase_d     = PH_RPAR;
					end
				end
				PH_RPAR: begin
					parity_d    = parity_q ^ line_in;
					bit_count_d = '0;
					phase_d     = PH_TRN_RD;
				end
				PH_TRN_RD: begin
					bit_count_d = cnt_inc;
					if (trn_end) begin
						bit_count_d = '0;
						phase_d     = PH_IDLE;
					end
				end
				PH_TRN_WR: begin
					bit_count_d = cnt_inc;
					if (trn_end) begin
						bit_count_d = '0;
						parity_d    = 1'b0;
						phase_d     = PH_WDATA;
					end
				end
				PH_WDATA: begin
					parity_d    = parity_q ^ shift_word_q[bit_pos];
					bit_count_d = cnt_inc;
					if (cnt_inc >= CNT_W'(DATA_WIDTH)) begin
						bit_count_d = '0;
						phase_d     = PH_WPAR;
					end
				end
				PH_WPAR: begin
					bit_count_d = '0;
					phase_d     = PH_IDLE;
				end
				default: begin
					bit_count_d = '0;
					phase_d     = PH_IDLE;
				end
			endcase
		end
	end

	// result of this word
	always_comb begin
		lo_c    = 1'b0;
		drv_c   = 1'b0;
		done_c  = 1'b0;
		stat_c  = ST_OK;
		rword_c = '0;
		if (cmd == CMD_REQ) begin
			drv_c = host_drives(phase_d);
		end else begin
			case (phase_q)
				PH_HDR: begin
					drv_c = 1'b1;
					lo_c  = header_bit(held_req_q, bit_count_q[2:0]);
				end
				PH_TRN_A, PH_ACK, PH_RDATA, PH_RPAR, PH_TRN_WR: begin
					drv_c = 1'b0;
				end
				PH_TRN_R: begin
					if (trn_end && (tries_q == 4'd0)) begin
						done_c = 1'b1;
						stat_c = (ack_q == ACK_WAIT) ? ST_WAIT : ST_FAULT;
					end
				end
				PH_TRN_RD: begin
					if (trn_end) begin
						done_c  = 1'b1;
						stat_c  = parity_q ? ST_PARITY : ST_OK;
						rword_c = shift_word_q;
					end
				end
				PH_WDATA: begin
					drv_c = 1'b1;
					lo_c  = shift_word_q[bit_pos];
				end
				PH_WPAR: begin
					drv_c  = 1'b1;
					lo_c   = parity_q;
					done_c = 1'b1;
				end
				default: begin
					drv_c = 1'b1;
				end
			endcase
		end
	end

	// advance transfer state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_word_q <= '0;
			parity_q     <= 1'b0;
			tries_q      <= 4'd0;
			held_req_q   <= 4'd0;
			ack_q        <= 3'd0;
		end else if (in_acc) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_word_q <= shift_word_d;
			parity_q     <= parity_d;
			tries_q      <= tries_d;
			held_req_q   <= held_req_d;
			ack_q        <= ack_d;
		end
	end

	// output valid: set on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold result payload until the next accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_out_q   <= lo_c;
			line_drive_q <= drv_c;
			busy_q       <= (phase_d != PH_IDLE);
			done_q       <= done_c;
			status_q     <= stat_c;
			last_ack_q   <= ack_d;
			read_word_q  <= rword_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_out   = line_out_q;
	assign line_drive = line_drive_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;
	assign status     = status_q;
	assign last_ack   = last_ack_q;
	assign read_word  = read_word_q;

	// checks
	`SWD_ASSERT_SAME(a_done_not_busy, clk, arst_n, out_valid_q && done_q, !busy_q, "done word while still busy")
	`SWD_ASSERT_SAME(a_released_low, clk, arst_n, out_valid_q && !line_drive_q, !line_out_q, "released line with nonzero level")
	`SWD_ASSERT_SAME(a_hdr_count, clk, arst_n, phase_q == PH_HDR, bit_count_q < CNT_W'(HDR_BITS), "header bit count out of range")
	`SWD_ASSERT_SAME(a_data_count, clk, arst_n, phase_q == PH_RDATA || phase_q == PH_WDATA, bit_count_q < CNT_W'(DATA_WIDTH), "data bit count out of range")
	`SWD_ASSERT_NEXT(a_wpar_done, clk, arst_n, in_acc && cmd == CMD_TICK && phase_q == PH_WPAR, out_valid_q && done_q && phase_q == PH_IDLE, "write parity tick did not complete")

endmodule

`default_nettype wire

// ===== tb/sv/swd_transfer_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD transfer monitor
// Watches both word channels and register writes of the SWD host transfer
// engine, predicts each result word from its own copy of the engine and
// compares it field by field; hands mismatch and outstanding counts upward.
// ----------------------------------------------------------------------------

module swd_transfer_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [3:0]  request_bits,
	input  logic [31:0] write_word,
	input  logic        line_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        line_out,
	input  logic        line_drive,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [1:0]  status,
	input  logic [2:0]  last_ack,
	input  logic [31:0] read_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatch_count,
	output int          words_due,
	output logic        engine_busy
);

	import swd_pkg::*;

	typedef struct packed {
		logic        lo;
		logic        drv;
		logic        busy;
		logic        done;
		logic [1:0]  st;
		logic [2:0]  ack;
		logic [31:0] rword;
	} bus_word_t;

	// Engine copy: transfer state and register values
	phase_t      ph;
	logic [5:0]  bit_cnt;
	logic [31:0] shreg;
	logic        par;
	logic [3:0]  tries;
	logic [3:0]  held_req;
	logic [2:0]  ack_bits;
	logic [3:0]  retry_lim;
	logic [2:0]  trn_cyc;

	bus_word_t due_words[$];

	assign engine_busy = (ph != PH_IDLE);

	// Advance the engine copy by one word and return the bus word it produces
	function automatic bus_word_t step_engine(input logic c, input logic [3:0] req,
			input logic [31:0] wd, input logic smp);
		bus_word_t   r;
		logic [5:0]  idx;
		logic [5:0]  nxt;
		logic [3:0]  trn;
		logic [7:0]  hdr;
		r   = '0;
		idx = bit_cnt;
		nxt = bit_cnt + 6'd1;
		trn = (trn_cyc == 3'd0) ? 4'd1 : {1'b0, trn_cyc};
		hdr = {1'b1, 1'b0, ^held_req, held_req, 1'b1};
		if (c == CMD_REQ) begin
			// latch a new transfer only when idle
			if (ph == PH_IDLE) begin
				held_req = req;
				shreg    = wd;
				tries    = (retry_lim == 4'd0) ? 4'd1 : retry_lim;
				par      = 1'b0;
				bit_cnt  = '0;
				ph       = PH_HDR;
			end
			r.drv = (ph == PH_IDLE) || (ph == PH_HDR) || (ph == PH_WDATA) || (ph == PH_WPAR);
		end else begin
			case (ph)
				PH_HDR: begin
					r.drv   = 1'b1;
					r.lo    = hdr[idx[2:0]];
					bit_cnt = nxt;
					if (idx >= 6'd7) begin
						ph      = PH_TRN_A;
						bit_cnt = '0;
					end
				end
				PH_TRN_A: begin
					bit_cnt = nxt;
					if (nxt >= trn) begin
						ph       = PH_ACK;
						bit_cnt  = '0;
						ack_bits = '0;
					end
				end
				PH_ACK: begin
					if (idx < ACK_BITS)
						ack_bits = ack_bits | ({2'b00, smp} << idx);
					bit_cnt = nxt;
					if (nxt >= ACK_BITS) begin
						bit_cnt = '0;
						if (ack_bits == ACK_OK) begin
							par = 1'b0;
							ph  = held_req[1] ? PH_RDATA : PH_TRN_WR;
						end else begin
							tries = (tries != 4'd0) ? tries - 4'd1 : 4'd0;
							ph    = PH_TRN_R;
						end
					end
				end
				PH_TRN_R: begin
					bit_cnt = nxt;
					if (nxt >= trn) begin
						bit_cnt = '0;
						if (tries != 4'd0) begin
							ph = PH_HDR;
						end else begin
							r.done = 1'b1;
							r.st   = (ack_bits == ACK_WAIT) ? ST_WAIT : ST_FAULT;
							ph     = PH_IDLE;
						end
					end
				end
				PH_RDATA: begin
					shreg[idx[4:0]] = smp;
					par             = par ^ smp;
					bit_cnt         = nxt;
					if (nxt >= DATA_WIDTH) begin
						bit_cnt = '0;
						ph      = PH_RPAR;
					end
				end
				PH_RPAR: begin
					par     = par ^ smp;
					bit_cnt = '0;
					ph      = PH_TRN_RD;
				end
				PH_TRN_RD: begin
					bit_cnt = nxt;
					if (nxt >= trn) begin
						r.done  = 1'b1;
						r.st    = par ? ST_PARITY : ST_OK;
						r.rword = shreg;
						bit_cnt = '0;
						ph      = PH_IDLE;
					end
				end
				PH_TRN_WR: begin
					bit_cnt = nxt;
					if (nxt >= trn) begin
						bit_cnt = '0;
						par     = 1'b0;
						ph      = PH_WDATA;
					end
				end
				PH_WDATA: begin
					r.drv   = 1'b1;
					r.lo    = shreg[idx[4:0]];
					par     = par ^ r.lo;
					bit_cnt = nxt;
					if (nxt >= DATA_WIDTH) begin
						bit_cnt = '0;
						ph      = PH_WPAR;
					end
				end
				PH_WPAR: begin
					r.drv   = 1'b1;
					r.lo    = par;
					r.done  = 1'b1;
					bit_cnt = '0;
					ph      = PH_IDLE;
				end
				default: begin
					// idle tick: drive the line low
					r.drv   = 1'b1;
					ph      = PH_IDLE;
					bit_cnt = '0;
				end
			endcase
		end
		r.busy = (ph != PH_IDLE);
		r.ack  = ack_bits;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare outgoing words, track register writes, predict incoming words
	always @(posedge clk or negedge arst_n) begin
		bus_word_t want;
		if (!arst_n) begin
			ph             = PH_IDLE;
			bit_cnt        = '0;
			shreg          = '0;
			par            = 1'b0;
			tries          = '0;
			held_req       = '0;
			ack_bits       = '0;
			retry_lim      = 4'd3;
			trn_cyc        = 3'd1;
			mismatch_count = 0;
			words_due      = 0;
			due_words.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					mismatch_count++;
				end else begin
					want = due_words.pop_front();
					compare_field("line_out", want.lo, line_out);
					compare_field("line_drive", want.drv, line_drive);
					compare_field("busy_res", want.busy, busy_res);
					compare_field("done_res", want.done, done_res);
					compare_field("status", want.st, status);
					compare_field("last_ack", want.ack, last_ack);
					compare_field("read_word", want.rword, read_word);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_RETRY: retry_lim = pwdata[3:0];
					REG_TRN:   trn_cyc   = pwdata[2:0];
					default:   ;
				endcase
			end
			if (in_valid && !in_stall)
				due_words.push_back(step_engine(cmd, request_bits, write_word, line_in));
			words_due = due_words.size();
		end
	end

endmodule

// ===== tb/sv/swd_host_transfer_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transfer engine testbench
// Drives whole SWD transfers (header, acknowledge with retries, read and
// write data with parity) as tick words under several register settings,
// with random idling on both channels, and reports the monitor's verdict.
// ----------------------------------------------------------------------------

module swd_host_transfer_engine_tb;

	import swd_pkg::*;

	localparam logic [2:0] ACK_FAULT = 3'd4;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [3:0]  request_bits;
	logic [31:0] write_word;
	logic        line_in;
	logic        out_valid;
	logic        out_stall;
	logic        line_out;
	logic        line_drive;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [2:0]  last_ack;
	logic [31:0] read_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatch_count;
	int          words_due;
	logic        engine_busy;

	int          words_sent;
	bit          sender_steady;
	bit          rx_quiet;
	bit          hold_output;
	logic [3:0]  cur_retry;
	logic [2:0]  cur_trn;

	swd_host_transfer_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.request_bits (request_bits),
		.write_word   (write_word),
		.line_in      (line_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_out     (line_out),
		.line_drive   (line_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.status       (status),
		.last_ack     (last_ack),
		.read_word    (read_word),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	swd_transfer_monitor monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.request_bits   (request_bits),
		.write_word     (write_word),
		.line_in        (line_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_out       (line_out),
		.line_drive     (line_drive),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.status         (status),
		.last_ack       (last_ack),
		.read_word      (read_word),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.words_due      (words_due),
		.engine_busy    (engine_busy)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Give up on a hung run
	initial begin
		#20_000_000;
		$display("swd_host_transfer_engine_tb failed");
		$finish;
	end

	// Result side: random stall runs, a long hold-off on request, quiet stretches
	initial begin
		int left;
		int r;
		out_stall   = 1'b0;
		hold_output = 1'b0;
		left        = 0;
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
				out_stall  <= 1'b0;
				hold_output = 1'b0;
				left        = 0;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else if (left == 0) begin
				r = $urandom_range(0, 99);
				out_stall <= ($urandom_range(0, 2) == 0);
				left = (r < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
			end else begin
				left--;
			end
		end
	end

	// Idle the sender for a random gap, mostly short, now and then long
	task automatic pause_sender();
		int r;
		int n;
		n = 0;
		if (!sender_steady) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				n = 0;
			else if (r < 90)
				n = $urandom_range(1, 3);
			else if (r < 97)
				n = $urandom_range(4, 10);
			else
				n = $urandom_range(20, 60);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one word and hold it until accepted
	task automatic put_word(input logic c, input logic [3:0] req, input logic [31:0] wd,
			input logic li);
		pause_sender();
		in_valid     <= 1'b1;
		cmd          <= c;
		request_bits <= req;
		write_word   <= wd;
		line_in      <= li;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic tick(input logic li);
		put_word(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, li);
	endtask

	// Stop sending and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		@(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [3:0] retry, input logic [2:0] trn);
		drain();
		reg_write(REG_RETRY, {28'd0, retry});
		reg_write(REG_TRN, {29'd0, trn});
		cur_retry = retry;
		cur_trn   = trn;
	endtask

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_ack();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return ACK_OK;
		else if (r < 82)
			return ACK_WAIT;
		else if (r < 92)
			return ACK_FAULT;
		return 3'($urandom_range(0, 7));
	endfunction

	// One well-formed transfer: header, acknowledge with retries, data phase
	task automatic run_transfer(input logic [3:0] req, input logic [31:0] wd);
		int         tl;
		int         tries_eff;
		logic [2:0] ack;
		logic [31:0] rdata;
		tl        = (cur_trn == 3'd0) ? 1 : int'(cur_trn);
		tries_eff = (cur_retry == 4'd0) ? 1 : int'(cur_retry);
		ack       = '0;
		put_word(CMD_REQ, req, wd, 1'($urandom_range(0, 1)));
		// a request while busy is dropped by the engine
		if ($urandom_range(0, 9) == 0)
			put_word(CMD_REQ, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)));
		for (int attempt = 1; attempt <= tries_eff; attempt++) begin
			repeat (HDR_BITS + tl) tick(1'($urandom_range(0, 1)));
			ack = pick_ack();
			for (int i = 0; i < ACK_BITS; i++) tick(ack[i]);
			if (ack == ACK_OK) break;
			repeat (tl) tick(1'($urandom_range(0, 1)));
		end
		if (ack == ACK_OK) begin
			if (req[1]) begin
				rdata = pick_word();
				for (int i = 0; i < DATA_WIDTH; i++) tick(rdata[i]);
				tick(^rdata ^ ($urandom_range(0, 7) == 0));
				repeat (tl) tick(1'($urandom_range(0, 1)));
			end else begin
				repeat (tl + DATA_WIDTH + 1) tick(1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Random words of any kind, then tick until the engine is idle again
	task automatic make_noise();
		repeat ($urandom_range(5, 20))
			put_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom,
				1'($urandom_range(0, 1)));
		drain();
		while (engine_busy) begin
			tick(1'($urandom_range(0, 1)));
			drain();
		end
	endtask

	task automatic run_phase(input int target);
		int r;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				run_transfer(4'($urandom_range(0, 15)), pick_word());
			else if (r < 94)
				repeat ($urandom_range(1, 4)) tick(1'($urandom_range(0, 1)));
			else
				make_noise();
		end
	endtask

	// Reset, directed words, then random transfers under several settings
	initial begin
		in_valid      = 1'b0;
		cmd           = CMD_TICK;
		request_bits  = '0;
		write_word    = '0;
		line_in       = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		words_sent    = 0;
		sender_steady = 1'b0;
		rx_quiet      = 1'b0;
		cur_retry     = 4'd3;
		cur_trn       = 3'd1;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Idle ticks, a busy request that is dropped, a WAIT with no retries left
		apply_settings(4'd1, 3'd1);
		put_word(CMD_TICK, 4'h0, 32'h0000_0000, 1'b0);
		put_word(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);
		put_word(CMD_REQ, 4'hF, 32'hFFFF_FFFF, 1'b1);
		put_word(CMD_REQ, 4'h0, 32'h0000_0000, 1'b0);
		repeat (HDR_BITS + 1) put_word(CMD_TICK, 4'h0, 32'h0000_0000, 1'b0);
		put_word(CMD_TICK, 4'h5, 32'h0000_0000, ACK_WAIT[0]);
		put_word(CMD_TICK, 4'hA, 32'hFFFF_FFFF, ACK_WAIT[1]);
		put_word(CMD_TICK, 4'h0, 32'h0000_0000, ACK_WAIT[2]);
		put_word(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 1'b1);

		apply_settings(4'd3, 3'd1);
		run_phase(230);

		// zero in both registers behaves as one
		apply_settings(4'd0, 3'd0);
		run_phase(430);

		// Hold off the result side while the sender keeps offering words
		apply_settings(4'd15, 3'd4);
		hold_output   = 1'b1;
		sender_steady = 1'b1;
		run_transfer(4'($urandom_range(0, 15)), pick_word());
		run_transfer(4'($urandom_range(0, 15)), pick_word());
		sender_steady = 1'b0;
		run_phase(650);

		// A stretch with no idling on either side
		apply_settings(4'd2, 3'd7);
		sender_steady = 1'b1;
		rx_quiet      = 1'b1;
		repeat (3) run_transfer(4'($urandom_range(0, 15)), pick_word());
		sender_steady = 1'b0;
		rx_quiet      = 1'b0;
		run_phase(850);

		apply_settings(4'($urandom_range(1, 15)), 3'($urandom_range(1, 4)));
		run_phase(1050);

		apply_settings(4'd3, 3'd2);
		run_phase(1250);

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && words_due == 0)
			$display("swd_host_transfer_engine_tb passed");
		else
			$display("swd_host_transfer_engine_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/swd_pkg.sv
rtl/core/swd_host_transfer_engine.sv
tb/sv/swd_transfer_monitor.sv
tb/sv/swd_host_transfer_engine_tb.sv
